// ===== rtl/nnsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsa_pkg: shared types and constants
// Field widths, status codes, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nnsa_pkg;

   // Field widths
   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int BPP_W    = 6;
   localparam int PITCH_W  = 15;
   localparam int OFFSET_W = 26;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 3;

   // Dividend is a coordinate times a size; the quotient has the same width.
   localparam int DIV_W      = COORD_W + DIM_W;
   localparam int DIV_STEPS  = DIV_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_BPP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_BPP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LINE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_LINE   = 3'd7;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                clear_pos;
      logic                div_x;
      logic                div_y;
      logic                save_sx;
      logic                save_sy;
      logic                mul;
      logic                sum;
      logic                load_rsp;
      logic [STATUS_W-1:0] status;
   } nnsa_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_done;
      logic bpp_equal;
      logic last_col;
      logic last_row;
   } nnsa_sts_type;

endpackage
`default_nettype wire

// ===== rtl/nnsa_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsa_div: restoring divider
// Unsigned division of a coordinate-times-size product by an image size,
// one quotient bit per cycle. The quotient is valid while done is high.
// ----------------------------------------------------------------------------
module nnsa_div
   import nnsa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIM_W-1:0] divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     q_ff, q_in;
   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [DIM_W-1:0]     div_ff, div_in;
   logic [DIM_W:0]       trial;
   logic                 fits;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial    = {rem_ff, q_ff[DIV_W-1]};
      fits     = (trial >= {1'b0, div_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         q_in     = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         q_in     = {q_ff[DIV_W-2:0], fits};
         rem_in   = fits ? DIM_W'(trial - {1'b0, div_ff}) : trial[DIM_W-1:0];
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the working registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   // A new division is never started while one is running.
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // Done is a single-cycle pulse at the end of a division.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

endmodule
`default_nettype wire

// ===== rtl/nnsa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsa_dp: scaling datapath
// Configuration registers, destination position counters, the shared divider,
// offset multipliers and the result register.
// ----------------------------------------------------------------------------
module nnsa_dp
   import nnsa_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PITCH_W-1:0]   csr_data,
   input  wire nnsa_cmd_type         cmd,
   output nnsa_sts_type              sts,
   output logic [COORD_W-1:0]        rsp_src_x,
   output logic [COORD_W-1:0]        rsp_src_y,
   output logic [COORD_W-1:0]        rsp_dst_x,
   output logic [COORD_W-1:0]        rsp_dst_y,
   output logic [OFFSET_W-1:0]       rsp_src_offset,
   output logic [OFFSET_W-1:0]       rsp_dst_offset,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end,
   output logic [STATUS_W-1:0]       rsp_status
);

   // Saturate a size register into 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   logic [DIM_W-1:0]   src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [BPP_W-1:0]   src_bpp_ff, dst_bpp_ff;
   logic [PITCH_W-1:0] src_line_ff, dst_line_ff;

   logic [COORD_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [DIV_W-1:0]    sx_ff, sy_ff;
   logic [OFFSET_W-1:0] p_src_row_ff, p_src_col_ff, p_dst_row_ff, p_dst_col_ff;
   logic [OFFSET_W-1:0] src_off_ff, dst_off_ff;
   logic [COORD_W-1:0]  x_ff, y_ff;
   logic                row_end_ff, frame_end_ff;

   logic [COORD_W-1:0]  rsp_src_x_ff, rsp_src_y_ff, rsp_dst_x_ff, rsp_dst_y_ff;
   logic [OFFSET_W-1:0] rsp_src_off_ff, rsp_dst_off_ff;
   logic                rsp_row_end_ff, rsp_frame_end_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic [2:0]       pix_bytes;
   logic [DIM_W-1:0] x_next, y_next;
   logic             last_col, last_row;
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_quotient;
   logic [DIM_W-1:0] div_divisor;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(1);
         src_height_ff <= DIM_W'(1);
         dst_width_ff  <= DIM_W'(1);
         dst_height_ff <= DIM_W'(1);
         src_bpp_ff    <= BPP_W'(32);
         dst_bpp_ff    <= BPP_W'(32);
         src_line_ff   <= PITCH_W'(16384);
         dst_line_ff   <= PITCH_W'(16384);
      end else if (csr_write) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[DIM_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_data[DIM_W-1:0];
            CSR_SRC_BPP:    src_bpp_ff    <= csr_data[BPP_W-1:0];
            CSR_DST_BPP:    dst_bpp_ff    <= csr_data[BPP_W-1:0];
            CSR_SRC_LINE:   src_line_ff   <= csr_data;
            CSR_DST_LINE:   dst_line_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective sizes, pixel size and end-of-row and end-of-frame tests.
   always_comb begin
      sw        = clamp_dim(src_width_ff);
      sh        = clamp_dim(src_height_ff);
      dw        = clamp_dim(dst_width_ff);
      dh        = clamp_dim(dst_height_ff);
      pix_bytes = src_bpp_ff[BPP_W-1:3];
      x_next    = {1'b0, cur_x_ff} + DIM_W'(1);
      y_next    = {1'b0, cur_y_ff} + DIM_W'(1);
      last_col  = (x_next >= dw);
      last_row  = (y_next >= dh);
   end

   // The divider takes the product straight from the multiplier into its register.
   assign div_start    = cmd.div_x | cmd.div_y;
   assign div_dividend = cmd.div_y ? DIV_W'(cur_y_ff) * DIV_W'(sh)
                                   : DIV_W'(cur_x_ff) * DIV_W'(sw);
   assign div_divisor  = cmd.div_y ? dh : dw;

   nnsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Destination position: cleared at frame start, stepped in raster order.
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (cmd.clear_pos) begin
         cur_x_in = '0;
         cur_y_in = '0;
      end else if (cmd.sum) begin
         if (last_col) begin
            cur_x_in = '0;
            cur_y_in = last_row ? '0 : y_next[COORD_W-1:0];
         end else begin
            cur_x_in = x_next[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

   // Quotients, offset products and sums; offsets wrap at their width.
   always_ff @(posedge clock) begin
      if (cmd.save_sx) begin
         sx_ff <= div_quotient;
      end
      if (cmd.save_sy) begin
         sy_ff <= div_quotient;
      end
      if (cmd.mul) begin
         p_src_row_ff <= OFFSET_W'(sy_ff) * OFFSET_W'(src_line_ff);
         p_src_col_ff <= OFFSET_W'(sx_ff) * OFFSET_W'(pix_bytes);
         p_dst_row_ff <= OFFSET_W'(cur_y_ff) * OFFSET_W'(dst_line_ff);
         p_dst_col_ff <= OFFSET_W'(cur_x_ff) * OFFSET_W'(pix_bytes);
      end
      if (cmd.sum) begin
         src_off_ff   <= p_src_row_ff + p_src_col_ff;
         dst_off_ff   <= p_dst_row_ff + p_dst_col_ff;
         x_ff         <= cur_x_ff;
         y_ff         <= cur_y_ff;
         row_end_ff   <= last_col;
         frame_end_ff <= last_col & last_row;
      end
   end

   // Result register; error and idle results carry zero fields.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.status;
         if (cmd.status == STATUS_OK) begin
            rsp_src_x_ff     <= sx_ff[COORD_W-1:0];
            rsp_src_y_ff     <= sy_ff[COORD_W-1:0];
            rsp_dst_x_ff     <= x_ff;
            rsp_dst_y_ff     <= y_ff;
            rsp_src_off_ff   <= src_off_ff;
            rsp_dst_off_ff   <= dst_off_ff;
            rsp_row_end_ff   <= row_end_ff;
            rsp_frame_end_ff <= frame_end_ff;
         end else begin
            rsp_src_x_ff     <= '0;
            rsp_src_y_ff     <= '0;
            rsp_dst_x_ff     <= '0;
            rsp_dst_y_ff     <= '0;
            rsp_src_off_ff   <= '0;
            rsp_dst_off_ff   <= '0;
            rsp_row_end_ff   <= 1'b0;
            rsp_frame_end_ff <= 1'b0;
         end
      end
   end

   assign sts.div_done  = div_done;
   assign sts.bpp_equal = (src_bpp_ff == dst_bpp_ff);
   assign sts.last_col  = last_col;
   assign sts.last_row  = last_row;

   assign rsp_src_x      = rsp_src_x_ff;
   assign rsp_src_y      = rsp_src_y_ff;
   assign rsp_dst_x      = rsp_dst_x_ff;
   assign rsp_dst_y      = rsp_dst_y_ff;
   assign rsp_src_offset = rsp_src_off_ff;
   assign rsp_dst_offset = rsp_dst_off_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/nnsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsa_ctrl: sequencing controller
// Accepts one request at a time, tracks the open frame, steps the datapath
// through both divisions and the offset arithmetic, and owns result valid.
// ----------------------------------------------------------------------------
module nnsa_ctrl
   import nnsa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_start_req,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire nnsa_sts_type sts,
   output nnsa_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD_X,
      ST_DIV_X,
      ST_DIV_Y,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic                frame_active_ff, frame_active_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in        = state_ff;
      frame_active_in = frame_active_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      cmd             = '0;
      cmd.status      = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_start_req) begin
                  if (!sts.bpp_equal) begin
                     frame_active_in = 1'b0;
                     status_in       = STATUS_MISMATCH;
                     state_in        = ST_OUT;
                  end else begin
                     cmd.clear_pos   = 1'b1;
                     frame_active_in = 1'b1;
                     status_in       = STATUS_OK;
                     state_in        = ST_PROD_X;
                  end
               end else if (!frame_active_ff) begin
                  status_in = STATUS_IDLE;
                  state_in  = ST_OUT;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = ST_PROD_X;
               end
            end
         end
         ST_PROD_X: begin
            cmd.div_x = 1'b1;
            state_in  = ST_DIV_X;
         end
         ST_DIV_X: begin
            if (sts.div_done) begin
               cmd.save_sx = 1'b1;
               cmd.div_y   = 1'b1;
               state_in    = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (sts.div_done) begin
               cmd.save_sy = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (sts.last_col && sts.last_row) begin
               frame_active_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_active_ff <= 1'b0;
         status_ff       <= STATUS_OK;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_active_ff <= frame_active_in;
         status_ff       <= status_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The last pixel of a frame closes the frame.
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && sts.last_col && sts.last_row) |=> !frame_active_ff)
      else $error("frame still open after its last pixel");

   // A finished result waits while the previous one has not been taken.
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("result register overwritten before transfer");

   // A mismatch result never leaves a frame open.
   a_mismatch_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && status_ff == STATUS_MISMATCH) |-> !frame_active_ff)
      else $error("frame open after bpp mismatch");

endmodule
`default_nettype wire

// ===== rtl/nearest_neighbor_scale_addr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addr: nearest-neighbor scaling address generator
// Gives source and destination coordinates and byte offsets for each
// destination pixel of a scaled frame.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes, always ready; index 0..7 selects the sizes,
//            bits per pixel and row pitches. Write only while the block idles.
//   req_*  : one request per transfer. req_start_req = 1 opens a frame at
//            pixel zero, 0 advances to the next destination pixel.
//   rsp_*  : one result per request, held in an output register until the
//            transfer completes.
// Sequence: both coordinates of a pixel result go through one shared divider
//   that retires a quotient bit per cycle, 25 bits each; error and idle results
//   skip the divisions. Requests are taken one at a time, and a new request is
//   taken while the previous result still waits; the block stalls at the end
//   of its work if the receiver has not taken that result.
// Reset: registers return to sizes of 1, 32 bits per pixel and pitches of
//   16384 bytes; no frame is open and no result is pending.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_addr
   import nnsa_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PITCH_W-1:0]   csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_start_req,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [COORD_W-1:0]        rsp_src_x,
   output logic [COORD_W-1:0]        rsp_src_y,
   output logic [COORD_W-1:0]        rsp_dst_x,
   output logic [COORD_W-1:0]        rsp_dst_y,
   output logic [OFFSET_W-1:0]       rsp_src_offset,
   output logic [OFFSET_W-1:0]       rsp_dst_offset,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end,
   output logic [STATUS_W-1:0]       rsp_status
);

   nnsa_cmd_type cmd;
   nnsa_sts_type sts;

   // Register writes never stall.
   assign csr_ready = 1'b1;

   nnsa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   nnsa_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_src_x      (rsp_src_x),
      .rsp_src_y      (rsp_src_y),
      .rsp_dst_x      (rsp_dst_x),
      .rsp_dst_y      (rsp_dst_y),
      .rsp_src_offset (rsp_src_offset),
      .rsp_dst_offset (rsp_dst_offset),
      .rsp_row_end    (rsp_row_end),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire
